### sv/kf2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_pkg
// shared types, codes and the micro-program of the two-state kalman filter
// ----------------------------------------------------------------------------
package kf2_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 20;

    // payload items
    typedef struct packed {
        logic signed [31:0] measured_position;
        logic signed [31:0] force_req;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] estimated_position;
        logic signed [31:0] estimated_velocity;
    } estimate_t;

    // register indexes
    localparam logic [2:0] REG_TRANS_POS_POS  = 3'd0;
    localparam logic [2:0] REG_TRANS_POS_VEL  = 3'd1;
    localparam logic [2:0] REG_TRANS_VEL_POS  = 3'd2;
    localparam logic [2:0] REG_TRANS_VEL_VEL  = 3'd3;
    localparam logic [2:0] REG_FORCE_GAIN_VEL = 3'd4;
    localparam logic [2:0] REG_NOISE_POS      = 3'd5;
    localparam logic [2:0] REG_NOISE_VEL      = 3'd6;
    localparam logic [2:0] REG_NOISE_MEAS     = 3'd7;

    localparam logic [31:0] RST_TRANS_POS_POS  = 32'd1048576;
    localparam logic [31:0] RST_TRANS_POS_VEL  = 32'd0;
    localparam logic [31:0] RST_TRANS_VEL_POS  = 32'd0;
    localparam logic [31:0] RST_TRANS_VEL_VEL  = 32'd1048576;
    localparam logic [31:0] RST_FORCE_GAIN_VEL = 32'd0;
    localparam logic [30:0] RST_NOISE_POS      = 31'd105;
    localparam logic [30:0] RST_NOISE_VEL      = 31'd1049;
    localparam logic [30:0] RST_NOISE_MEAS     = 31'd26214;

    // operations of the shared unit
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // operand / destination codes: scratch slots below 16, named values from 16 up
    localparam int TMP_DEPTH = 16;
    localparam logic [5:0] T0  = 6'd0;
    localparam logic [5:0] T1  = 6'd1;
    localparam logic [5:0] T2  = 6'd2;
    localparam logic [5:0] T3  = 6'd3;
    localparam logic [5:0] T4  = 6'd4;
    localparam logic [5:0] T5  = 6'd5;
    localparam logic [5:0] T6  = 6'd6;
    localparam logic [5:0] T7  = 6'd7;
    localparam logic [5:0] T8  = 6'd8;
    localparam logic [5:0] T9  = 6'd9;
    localparam logic [5:0] T10 = 6'd10;
    localparam logic [5:0] T11 = 6'd11;
    localparam logic [5:0] T12 = 6'd12;
    localparam logic [5:0] T13 = 6'd13;
    localparam logic [5:0] T14 = 6'd14;
    localparam logic [5:0] T15 = 6'd15;
    localparam logic [5:0] S_A00 = 6'd16;
    localparam logic [5:0] S_A01 = 6'd17;
    localparam logic [5:0] S_A10 = 6'd18;
    localparam logic [5:0] S_A11 = 6'd19;
    localparam logic [5:0] S_G   = 6'd20;
    localparam logic [5:0] S_NP  = 6'd21;
    localparam logic [5:0] S_NV  = 6'd22;
    localparam logic [5:0] S_NM  = 6'd23;
    localparam logic [5:0] S_X0  = 6'd24;
    localparam logic [5:0] S_X1  = 6'd25;
    localparam logic [5:0] S_P0  = 6'd26;
    localparam logic [5:0] S_P1  = 6'd27;
    localparam logic [5:0] S_P2  = 6'd28;
    localparam logic [5:0] S_P3  = 6'd29;
    localparam logic [5:0] S_Y   = 6'd30;
    localparam logic [5:0] S_U   = 6'd31;
    localparam logic [5:0] S_ONE = 6'd32;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] d;
    } micro_t;

    localparam int PROG_LEN = 49;
    localparam logic [5:0] PC_LAST = 6'(PROG_LEN - 1);

    function automatic micro_t micro(input logic [5:0] pc);
        micro_t m;
        m = '{OP_ADD, T0, T0, T0};
        case (pc)
            // state prediction
            6'd0:  m = '{OP_MUL, S_A00, S_X0, T0};
            6'd1:  m = '{OP_MUL, S_A01, S_X1, T1};
            6'd2:  m = '{OP_ADD, T0, T1, T2};
            6'd3:  m = '{OP_MUL, S_A10, S_X0, T0};
            6'd4:  m = '{OP_MUL, S_A11, S_X1, T1};
            6'd5:  m = '{OP_ADD, T0, T1, T3};
            6'd6:  m = '{OP_MUL, S_G, S_U, T0};
            6'd7:  m = '{OP_ADD, T3, T0, T3};
            // a * p
            6'd8:  m = '{OP_MUL, S_A00, S_P0, T0};
            6'd9:  m = '{OP_MUL, S_A01, S_P2, T1};
            6'd10: m = '{OP_ADD, T0, T1, T4};
            6'd11: m = '{OP_MUL, S_A00, S_P1, T0};
            6'd12: m = '{OP_MUL, S_A01, S_P3, T1};
            6'd13: m = '{OP_ADD, T0, T1, T5};
            6'd14: m = '{OP_MUL, S_A10, S_P0, T0};
            6'd15: m = '{OP_MUL, S_A11, S_P2, T1};
            6'd16: m = '{OP_ADD, T0, T1, T6};
            6'd17: m = '{OP_MUL, S_A10, S_P1, T0};
            6'd18: m = '{OP_MUL, S_A11, S_P3, T1};
            6'd19: m = '{OP_ADD, T0, T1, T7};
            // (a * p) * a' plus noise
            6'd20: m = '{OP_MUL, T4, S_A00, T0};
            6'd21: m = '{OP_MUL, T5, S_A01, T1};
            6'd22: m = '{OP_ADD, T0, T1, T0};
            6'd23: m = '{OP_ADD, T0, S_NP, T8};
            6'd24: m = '{OP_MUL, T4, S_A10, T0};
            6'd25: m = '{OP_MUL, T5, S_A11, T1};
            6'd26: m = '{OP_ADD, T0, T1, T9};
            6'd27: m = '{OP_MUL, T6, S_A00, T0};
            6'd28: m = '{OP_MUL, T7, S_A01, T1};
            6'd29: m = '{OP_ADD, T0, T1, T10};
            6'd30: m = '{OP_MUL, T6, S_A10, T0};
            6'd31: m = '{OP_MUL, T7, S_A11, T1};
            6'd32: m = '{OP_ADD, T0, T1, T0};
            6'd33: m = '{OP_ADD, T0, S_NV, T11};
            // gains
            6'd34: m = '{OP_ADD, T8, S_NM, T12};
            6'd35: m = '{OP_DIV, T8, T12, T13};
            6'd36: m = '{OP_DIV, T10, T12, T14};
            // estimate update
            6'd37: m = '{OP_SUB, S_Y, T2, T15};
            6'd38: m = '{OP_MUL, T13, T15, T0};
            6'd39: m = '{OP_ADD, T2, T0, S_X0};
            6'd40: m = '{OP_MUL, T14, T15, T0};
            6'd41: m = '{OP_ADD, T3, T0, S_X1};
            // covariance update
            6'd42: m = '{OP_SUB, S_ONE, T13, T1};
            6'd43: m = '{OP_MUL, T1, T8, S_P0};
            6'd44: m = '{OP_MUL, T1, T9, S_P1};
            6'd45: m = '{OP_MUL, T14, T8, T0};
            6'd46: m = '{OP_SUB, T10, T0, S_P2};
            6'd47: m = '{OP_MUL, T14, T9, T0};
            6'd48: m = '{OP_SUB, T11, T0, S_P3};
            default: m = '{OP_ADD, T0, T0, T0};
        endcase
        return m;
    endfunction

endpackage

### sv/kf2_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kf2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/kf2_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_alu
// shared saturating multiply / add / subtract unit in fixed point
// ----------------------------------------------------------------------------
module kf2_alu #(
    parameter int DATA_WIDTH = kf2_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kf2_pkg::FRAC_BITS_DEF
) (
    input  logic [1:0]                   op,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic signed [DATA_WIDTH-1:0] result
);

    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]     ma, mb;
    logic [2*W-1:0]   prod;
    logic [2*W:0]     prod_rnd;
    logic [2*W-F:0]   q;
    logic             big, neg;
    logic [W:0]       sum, dif;
    logic [W-1:0]     mul_res;

    always_comb
    begin
        ma       = a[W-1] ? W'(-a) : W'(a);
        mb       = b[W-1] ? W'(-b) : W'(b);
        neg      = a[W-1] ^ b[W-1];
        prod     = (2*W)'(ma) * (2*W)'(mb);
        prod_rnd = (2*W+1)'(prod) + ((2*W+1)'(1) << (F - 1));
        q        = prod_rnd[2*W:F];
        big      = |q[2*W-F:W-1];
        if (neg)
        begin
            mul_res = big ? MINV : W'(-q[W-1:0]);
        end
        else
        begin
            mul_res = big ? MAXV : q[W-1:0];
        end
        sum = {a[W-1], a} + {b[W-1], b};
        dif = {a[W-1], a} - {b[W-1], b};
        case (op)
            kf2_pkg::OP_MUL: result = mul_res;
            kf2_pkg::OP_ADD: result = (sum[W] != sum[W-1]) ? (sum[W] ? MINV : MAXV)
                                                           : sum[W-1:0];
            kf2_pkg::OP_SUB: result = (dif[W] != dif[W-1]) ? (dif[W] ? MINV : MAXV)
                                                           : dif[W-1:0];
            default:         result = '0;
        endcase
    end

endmodule

### sv/kf2_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_div
// iterative restoring divider, one quotient bit a cycle, rounded and saturated
// ----------------------------------------------------------------------------
module kf2_div #(
    parameter int DATA_WIDTH = kf2_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kf2_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] num,
    input  logic signed [DATA_WIDTH-1:0] den,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quot
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NB = W + F;
    localparam int CW = $clog2(NB + 1);
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic [NB-1:0] num_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;

    logic [W:0]    trial;
    logic          fits;
    logic [NB:0]   q_rnd;
    logic          big;

    always_comb
    begin
        trial = {rem_reg, num_reg[NB-1]};
        fits  = trial >= {1'b0, den_reg};
        q_rnd = (NB+1)'(num_reg) + (NB+1)'(({rem_reg, 1'b0}) >= {1'b0, den_reg});
        big   = |q_rnd[NB:W-1];
        if (neg_reg)
        begin
            quot = big ? MINV : W'(-q_rnd[W-1:0]);
        end
        else
        begin
            quot = big ? MAXV : q_rnd[W-1:0];
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {(num[W-1] ? W'(-num) : W'(num)), {F{1'b0}}};
            den_reg <= den[W-1] ? W'(-den) : W'(den);
            neg_reg <= num[W-1] ^ den[W-1];
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? W'(trial - {1'b0, den_reg}) : trial[W-1:0];
            num_reg <= {num_reg[NB-2:0], fits};
        end
    end

endmodule

### sv/two_state_kalman_filter_core.sv
`timescale 1ns / 1ps
// each micro-op passes through an issue and an execute state on the shared unit;
// the two gain divides run bit-serially on the divider and are skipped, giving a
// zero gain, for a zero innovation variance; a finishing state loads the output
// a stalled result holds back the finish only; no new item is taken before then,
// but a new item is taken while the previous result still waits at the output
// reset (rst_n, async, active low) restores registers to their defaults, the
// estimate to zero and the covariance to identity
// ----------------------------------------------------------------------------
// two_state_kalman_filter_core
// position/velocity kalman filter, micro-sequenced over one shared alu and
// one iterative divider, with an apb register port
// ----------------------------------------------------------------------------
module two_state_kalman_filter_core #(
    parameter int DATA_WIDTH = kf2_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kf2_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // sample channel
    input  logic               sample_valid,
    output logic               sample_stall,
    input  kf2_pkg::sample_t   sample,
    // estimate channel
    output logic               estimate_valid,
    input  logic               estimate_stall,
    output kf2_pkg::estimate_t estimate,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int XW = ((W > 32) ? W : 32) + 2;
    localparam int TA = $clog2(kf2_pkg::TMP_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    // clamp a wide signed value into the internal format
    function automatic logic [W-1:0] fit_w(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            return hi[W-1:0];
        else if (v < lo)
            return lo[W-1:0];
        else
            return v[W-1:0];
    endfunction

    // clamp an internal value to the 32-bit output fields
    function automatic logic [31:0] fit_32(input logic signed [W-1:0] v);
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        x  = XW'(v);
        hi = {{(XW-31){1'b0}}, {31{1'b1}}};
        lo = ~hi;
        if (x > hi)
            return hi[31:0];
        else if (x < lo)
            return lo[31:0];
        else
            return x[31:0];
    endfunction

    // raw register contents as written
    logic [31:0] trans_pos_pos_reg, trans_pos_vel_reg;
    logic [31:0] trans_vel_pos_reg, trans_vel_vel_reg;
    logic [31:0] force_gain_vel_reg;
    logic [30:0] noise_pos_reg, noise_vel_reg, noise_meas_reg;

    // filter state
    logic [W-1:0] x0_reg, x1_reg, p0_reg, p1_reg, p2_reg, p3_reg;
    logic [W-1:0] y_reg, u_reg;

    logic [2:0]   state_reg;
    logic [5:0]   pc_reg;
    logic         est_valid_reg;
    kf2_pkg::estimate_t est_reg;

    kf2_pkg::micro_t mi;
    logic [W-1:0] ram_a, ram_b;
    logic [W-1:0] opa, opb;
    logic [W-1:0] alu_res, div_res;
    logic         div_done, div_start;
    logic         wr_en;
    logic [W-1:0] wr_data;
    logic         sample_take, cfg_wr, fin_load;

    assign mi          = kf2_pkg::micro(pc_reg);
    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite;
    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_take = sample_valid & ~sample_stall;
    assign fin_load    = (state_reg == ST_FIN) & (~est_valid_reg | ~estimate_stall);
    assign estimate_valid = est_valid_reg;
    assign estimate    = est_reg;

    // operand selection for a source code
    function automatic logic [W-1:0] pick(input logic [5:0] code, input logic [W-1:0] tmp);
        logic [W-1:0] r;
        r = tmp;
        case (code)
            kf2_pkg::S_A00: r = fit_w(XW'($signed(trans_pos_pos_reg)));
            kf2_pkg::S_A01: r = fit_w(XW'($signed(trans_pos_vel_reg)));
            kf2_pkg::S_A10: r = fit_w(XW'($signed(trans_vel_pos_reg)));
            kf2_pkg::S_A11: r = fit_w(XW'($signed(trans_vel_vel_reg)));
            kf2_pkg::S_G:   r = fit_w(XW'($signed(force_gain_vel_reg)));
            kf2_pkg::S_NP:  r = fit_w(XW'(noise_pos_reg));
            kf2_pkg::S_NV:  r = fit_w(XW'(noise_vel_reg));
            kf2_pkg::S_NM:  r = fit_w(XW'(noise_meas_reg));
            kf2_pkg::S_X0:  r = x0_reg;
            kf2_pkg::S_X1:  r = x1_reg;
            kf2_pkg::S_P0:  r = p0_reg;
            kf2_pkg::S_P1:  r = p1_reg;
            kf2_pkg::S_P2:  r = p2_reg;
            kf2_pkg::S_P3:  r = p3_reg;
            kf2_pkg::S_Y:   r = y_reg;
            kf2_pkg::S_U:   r = u_reg;
            kf2_pkg::S_ONE: r = W'(1) << F;
            default:        r = tmp;
        endcase
        return r;
    endfunction

    // operands follow every register that pick reads
    always_comb
    begin
        opa = pick(mi.a, ram_a);
        opb = pick(mi.b, ram_b);
    end

    // zero innovation variance skips the divider and gives a zero gain
    assign div_start = (state_reg == ST_EXEC) && (mi.op == kf2_pkg::OP_DIV) && (opb != '0);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = alu_res;
        if (state_reg == ST_EXEC)
        begin
            if (mi.op == kf2_pkg::OP_DIV)
            begin
                wr_en   = (opb == '0);
                wr_data = '0;
            end
            else
            begin
                wr_en = 1'b1;
            end
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            wr_en   = 1'b1;
            wr_data = div_res;
        end
    end

    // scratch store, one copy for each read port
    kf2_ram #(.WIDTH(W), .DEPTH(kf2_pkg::TMP_DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (wr_en & ~mi.d[4] & ~mi.d[5]),
        .waddr (mi.d[TA-1:0]),
        .wdata (wr_data),
        .raddr (mi.a[TA-1:0]),
        .rdata (ram_a)
    );

    kf2_ram #(.WIDTH(W), .DEPTH(kf2_pkg::TMP_DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (wr_en & ~mi.d[4] & ~mi.d[5]),
        .waddr (mi.d[TA-1:0]),
        .wdata (wr_data),
        .raddr (mi.b[TA-1:0]),
        .rdata (ram_b)
    );

    kf2_alu #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_alu (
        .op     (mi.op),
        .a      (opa),
        .b      (opb),
        .result (alu_res)
    );

    kf2_div #(.DATA_WIDTH(W), .FRAC_BITS(F)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (opa),
        .den   (opb),
        .done  (div_done),
        .quot  (div_res)
    );

    // register read back
    always_comb
    begin
        unique case (paddr[4:2])
            kf2_pkg::REG_TRANS_POS_POS:  prdata = trans_pos_pos_reg;
            kf2_pkg::REG_TRANS_POS_VEL:  prdata = trans_pos_vel_reg;
            kf2_pkg::REG_TRANS_VEL_POS:  prdata = trans_vel_pos_reg;
            kf2_pkg::REG_TRANS_VEL_VEL:  prdata = trans_vel_vel_reg;
            kf2_pkg::REG_FORCE_GAIN_VEL: prdata = force_gain_vel_reg;
            kf2_pkg::REG_NOISE_POS:      prdata = {1'b0, noise_pos_reg};
            kf2_pkg::REG_NOISE_VEL:      prdata = {1'b0, noise_vel_reg};
            kf2_pkg::REG_NOISE_MEAS:     prdata = {1'b0, noise_meas_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_pos_pos_reg  <= kf2_pkg::RST_TRANS_POS_POS;
            trans_pos_vel_reg  <= kf2_pkg::RST_TRANS_POS_VEL;
            trans_vel_pos_reg  <= kf2_pkg::RST_TRANS_VEL_POS;
            trans_vel_vel_reg  <= kf2_pkg::RST_TRANS_VEL_VEL;
            force_gain_vel_reg <= kf2_pkg::RST_FORCE_GAIN_VEL;
            noise_pos_reg      <= kf2_pkg::RST_NOISE_POS;
            noise_vel_reg      <= kf2_pkg::RST_NOISE_VEL;
            noise_meas_reg     <= kf2_pkg::RST_NOISE_MEAS;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                kf2_pkg::REG_TRANS_POS_POS:  trans_pos_pos_reg  <= pwdata;
                kf2_pkg::REG_TRANS_POS_VEL:  trans_pos_vel_reg  <= pwdata;
                kf2_pkg::REG_TRANS_VEL_POS:  trans_vel_pos_reg  <= pwdata;
                kf2_pkg::REG_TRANS_VEL_VEL:  trans_vel_vel_reg  <= pwdata;
                kf2_pkg::REG_FORCE_GAIN_VEL: force_gain_vel_reg <= pwdata;
                kf2_pkg::REG_NOISE_POS:      noise_pos_reg      <= pwdata[30:0];
                kf2_pkg::REG_NOISE_VEL:      noise_vel_reg      <= pwdata[30:0];
                kf2_pkg::REG_NOISE_MEAS:     noise_meas_reg     <= pwdata[30:0];
                default:                     ;
            endcase
        end
    end

    // sequencer: issue reads the scratch store, exec runs the shared unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            est_valid_reg <= 1'b0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            p0_reg        <= W'(1) << F;
            p1_reg        <= '0;
            p2_reg        <= '0;
            p3_reg        <= W'(1) << F;
        end
        else
        begin
            if (est_valid_reg && !estimate_stall)
            begin
                est_valid_reg <= 1'b0;
            end
            // results aimed at named state
            if (wr_en)
            begin
                case (mi.d)
                    kf2_pkg::S_X0: x0_reg <= wr_data;
                    kf2_pkg::S_X1: x1_reg <= wr_data;
                    kf2_pkg::S_P0: p0_reg <= wr_data;
                    kf2_pkg::S_P1: p1_reg <= wr_data;
                    kf2_pkg::S_P2: p2_reg <= wr_data;
                    kf2_pkg::S_P3: p3_reg <= wr_data;
                    default:       ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_take)
                    begin
                        pc_reg    <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (div_start)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else if (pc_reg == kf2_pkg::PC_LAST)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_FIN:
                begin
                    if (fin_load)
                    begin
                        est_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // sampled inputs and output item
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            y_reg <= fit_w(XW'(sample.measured_position));
            u_reg <= fit_w(XW'(sample.force_req));
        end
        if (fin_load)
        begin
            est_reg.estimated_position <= fit_32(x0_reg);
            est_reg.estimated_velocity <= fit_32(x1_reg);
        end
    end

endmodule

### sv/kf2_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2_checker
// port-level checks of the kalman filter core, bound to the top level
// ----------------------------------------------------------------------------
module kf2_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic               estimate_valid,
    input logic               estimate_stall,
    input kf2_pkg::estimate_t estimate,
    input logic               pready
);

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("sample taken while block still idle");

    // no result can appear in the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> !$rose(estimate_valid))
        else $error("result appeared too soon after item");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        estimate_valid && estimate_stall |=> estimate_valid && $stable(estimate))
        else $error("stalled result changed");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind two_state_kalman_filter_core kf2_checker u_kf2_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .estimate_valid (estimate_valid),
    .estimate_stall (estimate_stall),
    .estimate       (estimate),
    .pready         (pready)
);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the position/velocity kalman filter against an in-bench fixed-point
// predictor, with random idling on both channels and register changes between
// phases
// ----------------------------------------------------------------------------

// scoreboard: keeps its own filter state and configuration, predicts one
// estimate per accepted sample and compares results in arrival order
class kf_scoreboard;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;
    localparam longint ONE  = 64'sd1048576;

    longint a00, a01, a10, a11, gain, np, nv, nm;
    longint x0, x1;
    longint p[4];
    kf2_pkg::estimate_t pending[$];
    int errors;
    int checked;

    function new();
        a00 = ONE; a01 = 0; a10 = 0; a11 = ONE; gain = 0;
        np = 105; nv = 1049; nm = 26214;
        x0 = 0; x1 = 0;
        p[0] = ONE; p[1] = 0; p[2] = 0; p[3] = ONE;
        errors = 0;
        checked = 0;
    endfunction

    function longint clip(longint v);
        if (v > MAXV) return MAXV;
        if (v < MINV) return MINV;
        return v;
    endfunction

    function longint sadd(longint a, longint b);
        return clip(a + b);
    endfunction

    function longint ssub(longint a, longint b);
        return clip(a - b);
    endfunction

    // exact product of two 32-bit values fits in 64 bits; round half away
    function longint qmul(longint a, longint b);
        logic neg;
        longint unsigned m;
        neg = (a < 0) != (b < 0);
        m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        m = (m + (64'd1 << 19)) >> 20;
        if (m > 64'd2147483648) m = 64'd2147483648;
        return neg ? clip(-longint'(m)) : clip(longint'(m));
    endfunction

    function longint qdiv(longint n, longint d);
        logic neg;
        longint unsigned un, ud, q, r;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = un / ud;
        r = un % ud;
        // magnitudes stay below 2^32, so the shifted quotient fits 53 bits
        if (q > 64'd2147483648) q = 64'd2147483649;
        else
        begin
            q = (q << 20) + (((r << 20) + (ud >> 1) + (ud & 1) - 1) / ud);
            // round half away: add one when twice the remainder reaches ud
            q = (un << 20) / ud;
            if ((((un << 20) % ud) << 1) >= ud) q = q + 1;
        end
        if (q > 64'd2147483648) q = 64'd2147483648;
        return neg ? clip(-longint'(q)) : clip(longint'(q));
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            kf2_pkg::REG_TRANS_POS_POS:  a00 = longint'(signed'(v));
            kf2_pkg::REG_TRANS_POS_VEL:  a01 = longint'(signed'(v));
            kf2_pkg::REG_TRANS_VEL_POS:  a10 = longint'(signed'(v));
            kf2_pkg::REG_TRANS_VEL_VEL:  a11 = longint'(signed'(v));
            kf2_pkg::REG_FORCE_GAIN_VEL: gain = longint'(signed'(v));
            kf2_pkg::REG_NOISE_POS:      np = longint'({1'b0, v[30:0]});
            kf2_pkg::REG_NOISE_VEL:      nv = longint'({1'b0, v[30:0]});
            kf2_pkg::REG_NOISE_MEAS:     nm = longint'({1'b0, v[30:0]});
            default: ;
        endcase
    endfunction

    function void note_sample(kf2_pkg::sample_t s);
        longint y, u, xp0, xp1, t00, t01, t10, t11, pp00, pp01, pp10, pp11;
        longint sv, k0, k1, innov, omk;
        kf2_pkg::estimate_t e;
        y = s.measured_position;
        u = s.force_req;
        xp0 = sadd(qmul(a00, x0), qmul(a01, x1));
        xp1 = sadd(sadd(qmul(a10, x0), qmul(a11, x1)), qmul(gain, u));
        t00 = sadd(qmul(a00, p[0]), qmul(a01, p[2]));
        t01 = sadd(qmul(a00, p[1]), qmul(a01, p[3]));
        t10 = sadd(qmul(a10, p[0]), qmul(a11, p[2]));
        t11 = sadd(qmul(a10, p[1]), qmul(a11, p[3]));
        pp00 = sadd(sadd(qmul(t00, a00), qmul(t01, a01)), np);
        pp01 = sadd(qmul(t00, a10), qmul(t01, a11));
        pp10 = sadd(qmul(t10, a00), qmul(t11, a01));
        pp11 = sadd(sadd(qmul(t10, a10), qmul(t11, a11)), nv);
        sv = sadd(pp00, nm);
        k0 = 0;
        k1 = 0;
        // zero innovation variance leaves the prediction untouched
        if (sv != 0)
        begin
            k0 = qdiv(pp00, sv);
            k1 = qdiv(pp10, sv);
        end
        innov = ssub(y, xp0);
        x0 = sadd(xp0, qmul(k0, innov));
        x1 = sadd(xp1, qmul(k1, innov));
        omk = ssub(ONE, k0);
        p[0] = qmul(omk, pp00);
        p[1] = qmul(omk, pp01);
        p[2] = ssub(pp10, qmul(k1, pp00));
        p[3] = ssub(pp11, qmul(k1, pp01));
        e.estimated_position = x0[31:0];
        e.estimated_velocity = x1[31:0];
        pending.push_back(e);
    endfunction

    function void check_estimate(kf2_pkg::estimate_t got);
        kf2_pkg::estimate_t want;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected estimate %h", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.estimated_position !== want.estimated_position ||
            got.estimated_velocity !== want.estimated_velocity)
        begin
            errors++;
            if (errors <= 10)
                $display("estimate %0d: pos exp %0d got %0d, vel exp %0d got %0d",
                         checked, want.estimated_position, got.estimated_position,
                         want.estimated_velocity, got.estimated_velocity);
        end
    endfunction
endclass

module tb;

    localparam int LATENCY = 2 * kf2_pkg::PROG_LEN + 2 * (32 + 20 + 1) + 1;
    localparam longint CYCLE_LIMIT = 2000000;

    logic               clk;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_stall;
    kf2_pkg::sample_t   sample;
    logic               estimate_valid;
    logic               estimate_stall;
    kf2_pkg::estimate_t estimate;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    kf_scoreboard board;
    longint cycles = 0;
    int samples_sent;
    int phases;

    two_state_kalman_filter_core dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .estimate_valid(estimate_valid), .estimate_stall(estimate_stall),
        .estimate(estimate),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // register write: setup then access, lands on the access edge, then the port goes idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_reg(idx, v);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays up after acceptance until the next gap or drain lowers it
    task automatic send_sample(logic [31:0] y, logic [31:0] u);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample.measured_position <= y;
        sample.force_req <= u;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        board.note_sample('{y, u});
        samples_sent++;
    endtask

    // wait until every expected estimate is back, then let the core settle
    task automatic drain();
        sample_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // random value with a bias towards extremes and small magnitudes
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(signed'($urandom_range(0, 4194304)) - 2097152);
            3, 4: return 32'(signed'($urandom_range(0, 200000000)) - 100000000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config(logic wild);
        write_reg(kf2_pkg::REG_TRANS_POS_POS,
                  wild ? pick_value() : 32'd1048576 + $urandom_range(0, 2000) - 1000);
        write_reg(kf2_pkg::REG_TRANS_POS_VEL, wild ? pick_value() : $urandom_range(0, 60000));
        write_reg(kf2_pkg::REG_TRANS_VEL_POS, wild ? pick_value() : 32'd0);
        write_reg(kf2_pkg::REG_TRANS_VEL_VEL,
                  wild ? pick_value() : 32'd1048576 - $urandom_range(0, 5000));
        write_reg(kf2_pkg::REG_FORCE_GAIN_VEL,
                  wild ? pick_value() : $urandom_range(0, 40000));
        write_reg(kf2_pkg::REG_NOISE_POS, wild ? pick_value() : $urandom_range(0, 2000));
        write_reg(kf2_pkg::REG_NOISE_VEL, wild ? pick_value() : $urandom_range(0, 20000));
        write_reg(kf2_pkg::REG_NOISE_MEAS, wild ? pick_value() : $urandom_range(1, 200000));
    endtask

    // result side: random stalls, every accepted estimate goes to the board
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (estimate_valid && !estimate_stall) board.check_estimate(estimate);
        end
    end

    initial
    begin : stall_gen
        int g;
        estimate_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                estimate_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            estimate_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // cycle guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        board = new();
        samples_sent = 0;
        phases = 0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes under reset settings
        send_sample(32'h0, 32'h0);
        send_sample(32'h7fffffff, 32'h7fffffff);
        send_sample(32'h80000000, 32'h80000000);
        send_sample(32'h7fffffff, 32'h80000000);
        send_sample(32'h00100000, 32'hffffffff);
        send_sample(32'hfff00000, 32'h00000001);
        drain();

        // directed: zero innovation variance, covariance collapsed and no noise
        write_reg(kf2_pkg::REG_TRANS_POS_POS, 32'd0);
        write_reg(kf2_pkg::REG_TRANS_POS_VEL, 32'd0);
        write_reg(kf2_pkg::REG_NOISE_POS, 32'd0);
        write_reg(kf2_pkg::REG_NOISE_MEAS, 32'd0);
        write_reg(kf2_pkg::REG_FORCE_GAIN_VEL, 32'h7fffffff);
        send_sample(32'h12345678, 32'h7fffffff);
        send_sample(32'h80000000, 32'h80000000);
        drain();

        // directed: negative innovation variance and extreme matrix entries
        write_reg(kf2_pkg::REG_TRANS_POS_POS, 32'h80000000);
        write_reg(kf2_pkg::REG_TRANS_POS_VEL, 32'h7fffffff);
        write_reg(kf2_pkg::REG_TRANS_VEL_POS, 32'h80000000);
        write_reg(kf2_pkg::REG_TRANS_VEL_VEL, 32'h7fffffff);
        write_reg(kf2_pkg::REG_NOISE_POS, 32'h7fffffff);
        write_reg(kf2_pkg::REG_NOISE_VEL, 32'hffffffff);
        write_reg(kf2_pkg::REG_NOISE_MEAS, 32'hffffffff);
        send_sample(32'h7fffffff, 32'h0);
        send_sample(32'h80000000, 32'h7fffffff);
        send_sample(32'h00000001, 32'h80000000);
        drain();
        write_reg(kf2_pkg::REG_NOISE_POS, 32'h0);
        write_reg(kf2_pkg::REG_NOISE_MEAS, 32'h80000000);
        write_reg(kf2_pkg::REG_TRANS_POS_POS, 32'h00100000);
        write_reg(kf2_pkg::REG_TRANS_POS_VEL, 32'h0);
        send_sample(32'hffffffff, 32'h1);
        send_sample(32'h00400000, 32'hffc00000);
        drain();

        // random phases: mostly plausible tracking settings, some wild ones
        while (samples_sent < 370)
        begin
            random_config($urandom_range(0, 3) == 0);
            phases++;
            repeat ($urandom_range(20, 60))
                send_sample(pick_value(), pick_value());
            // whole pipeline empties before the next register change
            drain();
        end

        $display("%0d samples over %0d random setting phases, %0d estimates checked",
                 samples_sent, phases, board.checked);
        $display("extreme fields, zero and negative innovation variance covered");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d estimates missing", board.errors,
                     board.pending.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
